// ----- design/nqse_pkg.sv -----
// Shared types, codes and constants of the N-queens solution enumerator.
package nqse_pkg;

    localparam int MAX_N_DEF = 8;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [3:0] board_size;
    } nqse_in_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  column;
        logic        last;
        logic        exhausted;
        logic [23:0] solution_index;
    } nqse_out_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRESH,
        PH_RESUME,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BACK,
        ST_EMIT,
        ST_EXH
    } state_t;

    typedef struct packed {
        logic start;
        logic place;
        logic retreat;
        logic solved;
        logic finish;
        logic emit_row;
        logic emit_exh;
    } ctl_t;

    typedef struct packed {
        phase_t phase;
        logic   row_full;
        logic   found;
        logic   r_zero;
        logic   emit_last;
        logic   out_free;
    } status_t;

endpackage

// ----- design/n_queens_solution_enumerator.sv -----
// Top level of the N-queens solution enumerator.
//
// Command channel (cmd_valid/cmd_stall/cmd_data): action start loads the board
// size (saturated to MAX_N; zero loads an ended search) and clears the search,
// giving no result. Action fetch resumes the depth-first search and returns the
// next solution as one beat per row on the solution channel
// (sol_valid/sol_stall/sol_data), last set on the final row, or one exhausted
// beat once no solution remains.
// A start is carried out as it is taken. A fetch is taken, then the sequencer
// places one queen per search step, backtracks by a failed row plus a retreat,
// detects a full board, then sends the row beats as the output register frees.
// cmd_stall is high from a fetch until its last beat enters the output
// register; the next command is taken while that beat waits.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the search to idle; a fetch then gives an exhausted beat with
// solution_index zero.
module n_queens_solution_enumerator #(
    parameter int MAX_N = nqse_pkg::MAX_N_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  nqse_pkg::nqse_in_t  cmd_data,
    output logic                sol_valid,
    input  logic                sol_stall,
    output nqse_pkg::nqse_out_t sol_data
);

    nqse_pkg::ctl_t    ctl;
    nqse_pkg::status_t st;

    nqse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .action    (cmd_data.action),
        .st        (st),
        .ctl       (ctl),
        .busy      (cmd_stall)
    );

    nqse_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .board_size (cmd_data.board_size),
        .ctl        (ctl),
        .st         (st),
        .sol_valid  (sol_valid),
        .sol_stall  (sol_stall),
        .sol_data   (sol_data)
    );

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.start, ctl.place, ctl.retreat, ctl.solved, ctl.finish,
                  ctl.emit_row, ctl.emit_exh}))
        else $error("more than one datapath command");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit_row || ctl.emit_exh) |-> (!sol_valid || !sol_stall))
        else $error("beat loaded over a stalled beat");

    a_solved_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.solved |=> (st.phase == nqse_pkg::PH_RESUME))
        else $error("solution found without resume phase");

    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.place |-> !st.row_full && st.found)
        else $error("queen placed beyond the board");
`endif

endmodule

// ----- design/nqse_ctrl.sv -----
// Search controller: sequences placement, backtracking and result beats.
module nqse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               action,
    input  nqse_pkg::status_t  st,
    output nqse_pkg::ctl_t     ctl,
    output logic               busy
);

    nqse_pkg::state_t state_reg;
    nqse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nqse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        busy       = (state_reg != nqse_pkg::ST_IDLE);
        case (state_reg)
            nqse_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (action == nqse_pkg::ACT_START)
                    begin
                        ctl.start = 1'b1;
                    end
                    else
                    begin
                        case (st.phase)
                            nqse_pkg::PH_FRESH:  state_next = nqse_pkg::ST_SEARCH;
                            nqse_pkg::PH_RESUME: state_next = nqse_pkg::ST_BACK;
                            default:             state_next = nqse_pkg::ST_EXH;
                        endcase
                    end
                end
            end
            nqse_pkg::ST_SEARCH:
            begin
                if (st.row_full)
                begin
                    ctl.solved = 1'b1;
                    state_next = nqse_pkg::ST_EMIT;
                end
                else if (st.found)
                begin
                    ctl.place = 1'b1;
                end
                else
                begin
                    state_next = nqse_pkg::ST_BACK;
                end
            end
            nqse_pkg::ST_BACK:
            begin
                if (st.r_zero)
                begin
                    ctl.finish = 1'b1;
                    state_next = nqse_pkg::ST_EXH;
                end
                else
                begin
                    ctl.retreat = 1'b1;
                    state_next  = nqse_pkg::ST_SEARCH;
                end
            end
            nqse_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    ctl.emit_row = 1'b1;
                    if (st.emit_last)
                    begin
                        state_next = nqse_pkg::ST_IDLE;
                    end
                end
            end
            nqse_pkg::ST_EXH:
            begin
                if (st.out_free)
                begin
                    ctl.emit_exh = 1'b1;
                    state_next   = nqse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nqse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/nqse_dp.sv -----
// Search datapath: occupancy masks, queen columns, counters and output register.
module nqse_dp #(
    parameter int MAX_N = nqse_pkg::MAX_N_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          board_size,
    input  nqse_pkg::ctl_t      ctl,
    output nqse_pkg::status_t   st,
    output logic                sol_valid,
    input  logic                sol_stall,
    output nqse_pkg::nqse_out_t sol_data
);

    localparam int CW  = $clog2(MAX_N);
    localparam int RW  = $clog2(MAX_N + 1);
    localparam int DW  = 2 * MAX_N;      // top bit is spare, never set
    localparam int DIW = $clog2(DW);

    logic [RW-1:0]        n_reg;
    logic [RW-1:0]        r_reg;
    logic [RW-1:0]        c_reg;
    logic [CW-1:0]        e_reg;
    logic [MAX_N-1:0]     cols_reg;
    logic [DW-1:0]        down_reg;
    logic [DW-1:0]        up_reg;
    logic [23:0]          count_reg;
    nqse_pkg::phase_t     phase_reg;
    logic [CW-1:0]        q_reg [MAX_N];
    logic                 out_valid_reg;
    nqse_pkg::nqse_out_t  out_reg;

    logic [MAX_N-1:0]     free;
    logic [CW-1:0]        pick;
    logic                 found;
    logic [CW-1:0]        q_addr;
    logic [CW-1:0]        q_rd;
    logic [RW-1:0]        tog_r;
    logic [CW-1:0]        tog_c;
    logic [MAX_N-1:0]     col_bit;
    logic [DW-1:0]        down_bit;
    logic [DW-1:0]        up_bit;
    logic [4:0]           size_ext;
    logic [RW-1:0]        size_sat;
    logic                 emit_last;
    logic                 out_free;

    always_comb
    begin
        for (int j = 0; j < MAX_N; j++)
        begin
            free[j] = (RW'(j) < n_reg) && (RW'(j) >= c_reg) && !cols_reg[j]
                && !down_reg[DIW'(r_reg) + DIW'(MAX_N - 1) - DIW'(j)]
                && !up_reg[DIW'(r_reg) + DIW'(j)];
        end
        pick = '0;
        for (int j = MAX_N - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                pick = CW'(j);
            end
        end
        found = |free;
    end

    assign q_addr = ctl.retreat ? CW'(r_reg - RW'(1)) : e_reg;
    assign q_rd   = q_reg[q_addr];

    always_comb
    begin
        if (ctl.retreat)
        begin
            tog_r = r_reg - RW'(1);
            tog_c = q_rd;
        end
        else
        begin
            tog_r = r_reg;
            tog_c = pick;
        end
        col_bit  = MAX_N'(1) << tog_c;
        down_bit = DW'(1) << (DIW'(tog_r) + DIW'(MAX_N - 1) - DIW'(tog_c));
        up_bit   = DW'(1) << (DIW'(tog_r) + DIW'(tog_c));
    end

    assign size_ext  = {1'b0, board_size};
    assign size_sat  = (size_ext > 5'(MAX_N)) ? RW'(MAX_N) : RW'(size_ext);
    assign emit_last = (RW'(e_reg) + RW'(1)) == n_reg;
    assign out_free  = !out_valid_reg || !sol_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            e_reg         <= '0;
            cols_reg      <= '0;
            down_reg      <= '0;
            up_reg        <= '0;
            count_reg     <= '0;
            phase_reg     <= nqse_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                n_reg     <= size_sat;
                r_reg     <= '0;
                c_reg     <= '0;
                e_reg     <= '0;
                cols_reg  <= '0;
                down_reg  <= '0;
                up_reg    <= '0;
                count_reg <= '0;
                phase_reg <= (size_sat == '0) ? nqse_pkg::PH_DONE : nqse_pkg::PH_FRESH;
            end
            if (ctl.place || ctl.retreat)
            begin
                cols_reg <= cols_reg ^ col_bit;
                down_reg <= down_reg ^ down_bit;
                up_reg   <= up_reg ^ up_bit;
            end
            if (ctl.place)
            begin
                r_reg <= r_reg + RW'(1);
                c_reg <= '0;
            end
            if (ctl.retreat)
            begin
                r_reg <= r_reg - RW'(1);
                c_reg <= RW'(q_rd) + RW'(1);
            end
            if (ctl.solved)
            begin
                phase_reg <= nqse_pkg::PH_RESUME;
                e_reg     <= '0;
            end
            if (ctl.finish)
            begin
                phase_reg <= nqse_pkg::PH_DONE;
            end
            if (ctl.emit_row)
            begin
                e_reg <= e_reg + CW'(1);
                if (emit_last)
                begin
                    count_reg <= count_reg + 24'd1;
                end
            end
            if (ctl.emit_row || ctl.emit_exh)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!sol_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.place)
        begin
            q_reg[CW'(r_reg)] <= pick;
        end
        if (ctl.emit_row)
        begin
            out_reg.row            <= 3'(e_reg);
            out_reg.column         <= 3'(q_rd);
            out_reg.last           <= emit_last;
            out_reg.exhausted      <= 1'b0;
            out_reg.solution_index <= count_reg;
        end
        else if (ctl.emit_exh)
        begin
            out_reg.row            <= '0;
            out_reg.column         <= '0;
            out_reg.last           <= 1'b1;
            out_reg.exhausted      <= 1'b1;
            out_reg.solution_index <= count_reg;
        end
    end

    assign st.phase     = phase_reg;
    assign st.row_full  = (r_reg >= n_reg);
    assign st.found     = found;
    assign st.r_zero    = (r_reg == '0);
    assign st.emit_last = emit_last;
    assign st.out_free  = out_free;

    assign sol_valid = out_valid_reg;
    assign sol_data  = out_reg;

endmodule

// ----- test/n_queens_solution_enumerator_tb.sv -----
// Testbench for the N-queens solution enumerator: a random-gap driver and sink check every beat.
module n_queens_solution_enumerator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N = nqse_pkg::MAX_N_DEF;
    localparam int unsigned QUIET_LIMIT = 50000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned SOL_TOTAL [0:8] = '{0, 1, 0, 0, 2, 10, 4, 40, 92};

    typedef struct {
        nqse_pkg::nqse_in_t beat;
        bit                 drain;
    } cmd_item_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    nqse_pkg::nqse_in_t  cmd_data = '0;
    logic                sol_valid;
    logic                sol_stall = 1'b0;
    nqse_pkg::nqse_out_t sol_data;

    cmd_item_t           cmd_q[$];
    nqse_pkg::nqse_out_t rows_due[$];
    int unsigned err_count = 0;
    int unsigned n_items = 0;
    int unsigned cyc = 0;
    bit          calm = 1'b0;
    bit          cmd_taken = 1'b0;
    bit          sol_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned sink_gap = 0;

    // search state of the expected behavior
    logic [2:0]         queen_at [MAX_N];
    int                 placed;
    int                 board_n;
    logic [MAX_N-1:0]   col_busy;
    logic [2*MAX_N-2:0] down_busy;
    logic [2*MAX_N-2:0] up_busy;
    logic [23:0]        sol_num;
    nqse_pkg::phase_t   phase;

    n_queens_solution_enumerator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .sol_valid (sol_valid),
        .sol_stall (sol_stall),
        .sol_data  (sol_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_search();
        for (int i = 0; i < MAX_N; i++)
            queen_at[i] = '0;
        placed = 0;
        board_n = 0;
        col_busy = '0;
        down_busy = '0;
        up_busy = '0;
        sol_num = '0;
        phase = nqse_pkg::PH_IDLE;
    endfunction

    function automatic void flip_queen(int r, int c);
        col_busy[c] = ~col_busy[c];
        down_busy[r + MAX_N - 1 - c] = ~down_busy[r + MAX_N - 1 - c];
        up_busy[r + c] = ~up_busy[r + c];
    endfunction

    // depth-first step to the next full placement; 0 when the search has ended
    function automatic bit seek_next();
        int r;
        int c;
        r = 0;
        c = 0;
        if (phase == nqse_pkg::PH_RESUME)
        begin
            r = (placed < board_n) ? placed : board_n;
            if (r == 0)
            begin
                phase = nqse_pkg::PH_DONE;
                return 1'b0;
            end
            r--;
            c = queen_at[r];
            flip_queen(r, c);
            c++;
        end
        forever
        begin
            if (r >= board_n)
            begin
                placed = board_n;
                phase = nqse_pkg::PH_RESUME;
                return 1'b1;
            end
            while (c < board_n && (col_busy[c] || down_busy[r + MAX_N - 1 - c] ||
                                   up_busy[r + c]))
                c++;
            if (c < board_n)
            begin
                queen_at[r] = c[2:0];
                flip_queen(r, c);
                r++;
                c = 0;
            end
            else
            begin
                if (r == 0)
                begin
                    placed = 0;
                    phase = nqse_pkg::PH_DONE;
                    return 1'b0;
                end
                r--;
                c = queen_at[r];
                flip_queen(r, c);
                c++;
            end
        end
    endfunction

    function automatic void predict_cmd(nqse_pkg::nqse_in_t cmd);
        nqse_pkg::nqse_out_t o;
        int                  sz;
        if (cmd.action == nqse_pkg::ACT_START)
        begin
            clear_search();
            sz = cmd.board_size;
            if (sz > MAX_N)
                sz = MAX_N;
            board_n = sz;
            phase = (sz == 0) ? nqse_pkg::PH_DONE : nqse_pkg::PH_FRESH;
            return;
        end
        if (phase == nqse_pkg::PH_IDLE || phase == nqse_pkg::PH_DONE || !seek_next())
        begin
            o = '0;
            o.last = 1'b1;
            o.exhausted = 1'b1;
            o.solution_index = sol_num;
            rows_due.insert(rows_due.size(), o);
            return;
        end
        for (int r = 0; r < board_n; r++)
        begin
            o = '0;
            o.row = r[2:0];
            o.column = queen_at[r];
            o.last = (r + 1 == board_n);
            o.solution_index = sol_num;
            rows_due.insert(rows_due.size(), o);
        end
        sol_num = sol_num + 24'd1;
    endfunction

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic flag_field(string name, int unsigned want, int unsigned got);
        err_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    task automatic add_cmd(logic act, int unsigned sz, bit drain);
        cmd_item_t it;
        it.beat.action = act;
        it.beat.board_size = sz[3:0];
        it.drain = drain;
        cmd_q.insert(cmd_q.size(), it);
        n_items++;
    endtask

    // monitor: checks result beats, predicts accepted commands
    always @(posedge clk)
    begin
        nqse_pkg::nqse_out_t want;
        if (rst_n)
        begin
            cyc++;
            calm = (cyc % 600) < 120;
            if (sol_valid && !sol_stall)
            begin
                if (rows_due.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected beat, expected none, got row %0d col %0d last %0b exh %0b idx %0d",
                             $time, sol_data.row, sol_data.column, sol_data.last,
                             sol_data.exhausted, sol_data.solution_index);
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (sol_data.row !== want.row)
                        flag_field("row", want.row, sol_data.row);
                    if (sol_data.column !== want.column)
                        flag_field("column", want.column, sol_data.column);
                    if (sol_data.last !== want.last)
                        flag_field("last", want.last, sol_data.last);
                    if (sol_data.exhausted !== want.exhausted)
                        flag_field("exhausted", want.exhausted, sol_data.exhausted);
                    if (sol_data.solution_index !== want.solution_index)
                        flag_field("solution_index", want.solution_index,
                                   sol_data.solution_index);
                end
            end
            if (cmd_valid && !cmd_stall)
                predict_cmd(cmd_data);
        end
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        sol_taken <= rst_n && sol_valid && !sol_stall;
    end

    // command driver
    always @(negedge clk)
    begin
        logic               v_next;
        nqse_pkg::nqse_in_t d_next;
        cmd_item_t          it;
        if (rst_n)
        begin
            v_next = cmd_valid;
            d_next = cmd_data;
            if (cmd_valid && cmd_taken)
            begin
                v_next = 1'b0;
                send_gap = draw_gap();
            end
            if (!v_next && send_gap > 0)
                send_gap--;
            else if (!v_next && cmd_q.size() > 0 &&
                     !(cmd_q[0].drain && rows_due.size() != 0))
            begin
                it = cmd_q.pop_front();
                v_next = 1'b1;
                d_next = it.beat;
            end
            cmd_valid <= v_next;
            cmd_data <= d_next;
        end
    end

    // result sink
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sol_taken)
                sink_gap = draw_gap();
            sol_stall <= (sink_gap > 0);
            if (sink_gap > 0 && sol_valid)
                sink_gap--;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (sol_valid && !sol_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sz;
        int unsigned eff;
        int unsigned n_fetch;
        int unsigned pick;
        clear_search();

        // directed
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 15, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 1, 1'b1);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 8, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 2, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 3, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 7, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 4, 1'b1);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 15, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 8, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 9, 1'b0);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);
        add_cmd(nqse_pkg::ACT_START, 6, 1'b1);
        add_cmd(nqse_pkg::ACT_FETCH, 0, 1'b0);

        // random: mostly start-then-fetch runs, some stray commands
        while (n_items < 150)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    sz = 0;
                else if (pick == 1)
                    sz = $urandom_range(9, 15);
                else if (pick < 5)
                    sz = 8;
                else
                    sz = $urandom_range(1, 7);
                eff = (sz > MAX_N) ? MAX_N : sz;
                n_fetch = SOL_TOTAL[eff] + 2;
                if (n_fetch > 24)
                    n_fetch = 24;
                add_cmd(nqse_pkg::ACT_START, sz, $urandom_range(0, 7) == 0);
                repeat ($urandom_range(1, n_fetch))
                    add_cmd(nqse_pkg::ACT_FETCH, $urandom_range(0, 15), 1'b0);
            end
            else
                add_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 15), 1'b0);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || cmd_valid || rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
